>>> rtl/core/uart_rx_tx_ring_buffer_engine_top_defines.svh
// ----------------------------------------------------------------------------
// UART ring buffer engine assertion macros
// Shared property wrappers for the checker of the engine ports.
// ----------------------------------------------------------------------------
`ifndef UART_RX_TX_RING_BUFFER_ENGINE_TOP_DEFINES_SVH
`define UART_RX_TX_RING_BUFFER_ENGINE_TOP_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define URB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define URB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/core/urb_pkg.sv
// ----------------------------------------------------------------------------
// UART ring buffer engine package
// Ring sizes, request and status codes, item and result types.
// ----------------------------------------------------------------------------
package urb_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 64;
    localparam int PTR_SPAN   = 2 * RING_DEPTH;
    localparam int PTR_W      = $clog2(PTR_SPAN);
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int DATA_W     = 8;
    localparam int LEVEL_W    = 7;
    localparam int OVR_W      = 16;

    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(PTR_SPAN - 1);
    localparam logic [PTR_W-1:0] LVL_FULL   = PTR_W'(RING_DEPTH);
    localparam logic [PTR_W-1:0] LVL_NFULL  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] LVL_ONE    = PTR_W'(1);
    localparam logic [OVR_W-1:0] OVR_MAX    = '1;

    // Request codes
    localparam logic [2:0] REQ_SERVICE = 3'd0;
    localparam logic [2:0] REQ_TX_WR   = 3'd1;
    localparam logic [2:0] REQ_RX_RD   = 3'd2;
    localparam logic [2:0] REQ_OPEN    = 3'd3;
    localparam logic [2:0] REQ_CLOSE   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NOT_OPEN     = 2'd1;
    localparam logic [1:0] ST_ALREADY_OPEN = 2'd2;
    localparam logic [1:0] ST_WOULD_BLOCK  = 2'd3;

    typedef struct packed {
        logic [2:0]        req_type;
        logic              line_dr;
        logic              line_thre;
        logic              line_oe;
        logic [DATA_W-1:0] rx_data;
        logic [DATA_W-1:0] tx_data;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [DATA_W-1:0]  rx_byte_out;
        logic               rbr_taken;
        logic               thr_write;
        logic [DATA_W-1:0]  thr_data;
        logic               ier_rx_enable;
        logic               ier_tx_enable;
        logic [OVR_W-1:0]   overruns;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } t_result;

    // Ring command from the controller
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_ring_cmd;

    // Ring occupancy seen by the controller
    typedef struct packed {
        logic             full;
        logic             near_full;
        logic             empty;
        logic             near_empty;
        logic [PTR_W-1:0] level;
    } t_ring_stat;

endpackage

>>> rtl/core/uart_rx_tx_ring_buffer_engine_top.sv
// ----------------------------------------------------------------------------
// UART ring buffer engine
// Receive and transmit byte rings with interrupt enables and overrun count.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on i_req and raise start; it is taken at any rising edge
//   where start is high and busy is low. busy stays low, so an item may be
//   issued in every cycle.
//   Each item gives one result on o_result, marked by o_done for exactly one
//   cycle, registered at the accepting edge. Throughput is one item per
//   cycle; the result is registered, and the registered read port of the
//   ring stores supplies popped bytes in the result cycle.
//   Levels, enables and the overrun count in a result are the state left
//   after that item.
//   The result receiver cannot stall: o_done is a strobe and must be taken
//   in the cycle it appears.
//   Synchronous reset (i_rst_n low) closes the engine, empties both rings,
//   clears the enables and the overrun count. The byte stores are not
//   cleared; only bytes pushed earlier are ever read back.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffer_engine_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  urb_pkg::t_req    i_req,
    output logic             o_done,
    output urb_pkg::t_result o_result
);

    logic                       accept;
    urb_pkg::t_ring_cmd         rx_cmd, tx_cmd;
    urb_pkg::t_ring_stat        rx_stat, tx_stat;
    logic [urb_pkg::DATA_W-1:0] rx_rdata, tx_rdata;
    logic [1:0]                 status;
    logic                       rbr_taken, thr_write, rx_popped;
    logic                       rx_en, tx_en;
    logic [urb_pkg::OVR_W-1:0]  overruns;

    // Take an item in every cycle
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    urb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_rx_stat   (rx_stat),
        .i_tx_stat   (tx_stat),
        .o_rx_cmd    (rx_cmd),
        .o_tx_cmd    (tx_cmd),
        .o_done      (o_done),
        .o_status    (status),
        .o_rbr_taken (rbr_taken),
        .o_thr_write (thr_write),
        .o_rx_popped (rx_popped),
        .o_rx_en     (rx_en),
        .o_tx_en     (tx_en),
        .o_overruns  (overruns)
    );

    urb_ring u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rx_cmd),
        .i_wdata (i_req.rx_data),
        .o_stat  (rx_stat),
        .o_rdata (rx_rdata)
    );

    urb_ring u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tx_cmd),
        .i_wdata (i_req.tx_data),
        .o_stat  (tx_stat),
        .o_rdata (tx_rdata)
    );

    // Assemble the result from registered flags and post-item state
    always_comb begin
        o_result.status        = status;
        o_result.rx_byte_out   = rx_popped ? rx_rdata : '0;
        o_result.rbr_taken     = rbr_taken;
        o_result.thr_write     = thr_write;
        o_result.thr_data      = thr_write ? tx_rdata : '0;
        o_result.ier_rx_enable = rx_en;
        o_result.ier_tx_enable = tx_en;
        o_result.overruns      = overruns;
        o_result.rx_level      = urb_pkg::LEVEL_W'(rx_stat.level);
        o_result.tx_level      = urb_pkg::LEVEL_W'(tx_stat.level);
    end

endmodule

>>> rtl/core/urb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/urb_ring.sv
// ----------------------------------------------------------------------------
// Byte ring
// Head and tail pointers over twice the depth, occupancy flags, byte store.
// ----------------------------------------------------------------------------
module urb_ring (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  urb_pkg::t_ring_cmd        i_cmd,
    input  logic [urb_pkg::DATA_W-1:0] i_wdata,
    output urb_pkg::t_ring_stat       o_stat,
    output logic [urb_pkg::DATA_W-1:0] o_rdata
);

    logic [urb_pkg::PTR_W-1:0]  r_head, r_tail;
    logic [urb_pkg::PTR_W-1:0]  n_head, n_tail;
    logic [urb_pkg::PTR_W:0]    wrap_sum;
    logic [urb_pkg::PTR_W-1:0]  level;
    logic [urb_pkg::ADDR_W-1:0] head_slot, tail_slot;

    // Occupancy: tail minus head modulo the pointer span
    always_comb begin
        wrap_sum = {1'b0, r_tail} + (urb_pkg::PTR_W + 1)'(urb_pkg::PTR_SPAN)
                   - {1'b0, r_head};
        if (r_tail >= r_head) begin
            level = r_tail - r_head;
        end else begin
            level = wrap_sum[urb_pkg::PTR_W-1:0];
        end
    end

    always_comb begin
        o_stat.level      = level;
        o_stat.full       = (level == urb_pkg::LVL_FULL);
        o_stat.near_full  = (level == urb_pkg::LVL_NFULL);
        o_stat.empty      = (level == '0);
        o_stat.near_empty = (level == urb_pkg::LVL_ONE);
    end

    // Map pointers onto store slots
    always_comb begin
        if (r_head >= urb_pkg::LVL_FULL) begin
            head_slot = urb_pkg::ADDR_W'(r_head - urb_pkg::LVL_FULL);
        end else begin
            head_slot = urb_pkg::ADDR_W'(r_head);
        end
        if (r_tail >= urb_pkg::LVL_FULL) begin
            tail_slot = urb_pkg::ADDR_W'(r_tail - urb_pkg::LVL_FULL);
        end else begin
            tail_slot = urb_pkg::ADDR_W'(r_tail);
        end
    end

    // Advance or clear the pointers
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_cmd.clear) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (i_cmd.push) begin
                n_tail = (r_tail == urb_pkg::PTR_LAST) ? '0 : r_tail + 1'b1;
            end
            if (i_cmd.pop) begin
                n_head = (r_head == urb_pkg::PTR_LAST) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    urb_ram #(
        .WIDTH (urb_pkg::DATA_W),
        .DEPTH (urb_pkg::RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (tail_slot),
        .i_wdata (i_wdata),
        .i_re    (i_cmd.pop),
        .i_raddr (head_slot),
        .o_rdata (o_rdata)
    );

endmodule

>>> rtl/core/urb_ctrl.sv
// ----------------------------------------------------------------------------
// Request controller
// Decodes one item, drives both rings, keeps flags, enables and overruns.
// ----------------------------------------------------------------------------
module urb_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  urb_pkg::t_req             i_req,
    input  urb_pkg::t_ring_stat       i_rx_stat,
    input  urb_pkg::t_ring_stat       i_tx_stat,
    output urb_pkg::t_ring_cmd        o_rx_cmd,
    output urb_pkg::t_ring_cmd        o_tx_cmd,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic                      o_rbr_taken,
    output logic                      o_thr_write,
    output logic                      o_rx_popped,
    output logic                      o_rx_en,
    output logic                      o_tx_en,
    output logic [urb_pkg::OVR_W-1:0] o_overruns
);

    logic                      r_open, n_open;
    logic                      r_rx_en, n_rx_en;
    logic                      r_tx_en, n_tx_en;
    logic [urb_pkg::OVR_W-1:0] r_ovr, n_ovr;
    logic                      r_done;
    logic [1:0]                r_status, n_status;
    logic                      r_taken, r_thr_w, r_rx_pop;

    // Decode the item against the current ring occupancy
    always_comb begin
        n_open   = r_open;
        n_rx_en  = r_rx_en;
        n_tx_en  = r_tx_en;
        n_ovr    = r_ovr;
        n_status = urb_pkg::ST_OK;
        o_rx_cmd = '0;
        o_tx_cmd = '0;
        if (i_accept) begin
            unique case (i_req.req_type)
                urb_pkg::REQ_SERVICE: begin
                    if (!r_open) begin
                        n_status = urb_pkg::ST_NOT_OPEN;
                    end else begin
                        o_rx_cmd.push = i_req.line_dr & ~i_rx_stat.full;
                        o_tx_cmd.pop  = i_req.line_thre & ~i_tx_stat.empty;
                        // drop the enables when the rings end full or empty
                        if (i_rx_stat.full || (i_rx_stat.near_full && o_rx_cmd.push)) begin
                            n_rx_en = 1'b0;
                        end
                        if (i_tx_stat.empty || (i_tx_stat.near_empty && o_tx_cmd.pop)) begin
                            n_tx_en = 1'b0;
                        end
                        if (i_req.line_oe && (r_ovr != urb_pkg::OVR_MAX)) begin
                            n_ovr = r_ovr + 1'b1;
                        end
                    end
                end
                urb_pkg::REQ_TX_WR: begin
                    if (!r_open) begin
                        n_status = urb_pkg::ST_NOT_OPEN;
                    end else if (i_tx_stat.full) begin
                        n_status = urb_pkg::ST_WOULD_BLOCK;
                    end else begin
                        o_tx_cmd.push = 1'b1;
                        n_tx_en       = 1'b1;
                    end
                end
                urb_pkg::REQ_RX_RD: begin
                    if (!r_open) begin
                        n_status = urb_pkg::ST_NOT_OPEN;
                    end else begin
                        n_rx_en = 1'b1;
                        if (i_rx_stat.empty) begin
                            n_status = urb_pkg::ST_WOULD_BLOCK;
                        end else begin
                            o_rx_cmd.pop = 1'b1;
                        end
                    end
                end
                urb_pkg::REQ_OPEN: begin
                    if (r_open) begin
                        n_status = urb_pkg::ST_ALREADY_OPEN;
                    end else begin
                        o_rx_cmd.clear = 1'b1;
                        o_tx_cmd.clear = 1'b1;
                        n_rx_en        = 1'b1;
                        n_tx_en        = 1'b0;
                        n_open         = 1'b1;
                    end
                end
                urb_pkg::REQ_CLOSE: begin
                    if (!r_open) begin
                        n_status = urb_pkg::ST_NOT_OPEN;
                    end else begin
                        n_rx_en = 1'b0;
                        n_tx_en = 1'b0;
                        n_open  = 1'b0;
                    end
                end
                default: begin
                    n_status = urb_pkg::ST_OK;
                end
            endcase
        end
    end

    // Hold engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_rx_en <= 1'b0;
            r_tx_en <= 1'b0;
            r_ovr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_open  <= n_open;
            r_rx_en <= n_rx_en;
            r_tx_en <= n_tx_en;
            r_ovr   <= n_ovr;
            r_done  <= i_accept;
        end
    end

    // Register the per-item result flags
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_taken  <= o_rx_cmd.push;
        r_thr_w  <= o_tx_cmd.pop;
        r_rx_pop <= o_rx_cmd.pop;
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_rbr_taken = r_taken;
    assign o_thr_write = r_thr_w;
    assign o_rx_popped = r_rx_pop;
    assign o_rx_en     = r_rx_en;
    assign o_tx_en     = r_tx_en;
    assign o_overruns  = r_ovr;

endmodule

>>> rtl/core/urb_checker.sv
// ----------------------------------------------------------------------------
// UART ring buffer engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_rx_tx_ring_buffer_engine_top_defines.svh"

module urb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input urb_pkg::t_req    i_req,
    input logic             o_done,
    input urb_pkg::t_result o_result
);

    logic [urb_pkg::LEVEL_W-1:0] lvl_max;
    logic                        accepted;
    logic                        moved;
    logic                        status_ok;
    logic                        lvl_ok;

    assign lvl_max   = urb_pkg::LEVEL_W'(urb_pkg::RING_DEPTH);
    assign accepted  = start && !busy;
    assign moved     = o_done && (o_result.rbr_taken || o_result.thr_write);
    assign status_ok = (o_result.status == urb_pkg::ST_OK);
    assign lvl_ok    = (o_result.rx_level <= lvl_max) && (o_result.tx_level <= lvl_max);

    // Every accepted item gives one result in the next cycle, and no other
    `URB_ASSERT(a_done_follows, accepted |=> o_done, "accepted item gave no result")
    `URB_ASSERT(a_no_stray_done, !accepted |=> !o_done, "result without an item")
    // No result in the cycle after a reset cycle
    `URB_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_done, "result after reset")
    // Ring moves only happen on a successful item
    `URB_ASSERT(a_move_ok, moved |-> status_ok, "ring moved on failed item")
    // Levels never exceed the ring depth
    `URB_ASSERT(a_level_max, o_done |-> lvl_ok, "ring level beyond depth")

endmodule

bind uart_rx_tx_ring_buffer_engine_top urb_checker u_urb_checker (.*);
